FILE: design/cau_pkg.sv
// Package for the complex arithmetic unit: widths, operation codes, the
// pipeline record handed from cell to cell and the rounding helpers.
// No dependencies.
`default_nettype none

package cau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 12;
   localparam int OP_W       = 3;

   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int SUM_W      = PROD_W + 1;
   localparam int MAG_W      = PROD_W;
   localparam int UMAG_W     = DATA_WIDTH + 1;
   // The quotient carries one guard bit for rounding and one bit for overflow.
   localparam int QUO_W      = DATA_WIDTH + 1;
   localparam int LOW_W      = QUO_W - FRAC_BITS - 1;
   localparam int SQRT_STEPS = DATA_WIDTH;

   localparam int ANG_W      = 64;
   localparam int ANG_FRAC   = 60;
   localparam int CORDIC_N   = 61;
   localparam int NORM_MSB   = 58;
   localparam int ANG_SHIFT  = ANG_FRAC - FRAC_BITS;
   localparam int STEP_W     = $clog2(CORDIC_N);
   localparam int MSB_W      = $clog2(UMAG_W);
   localparam int SHIFT_W    = $clog2(NORM_MSB + 1);

   localparam logic [ANG_W-1:0] ONE_Q60        = ANG_W'(1) << ANG_FRAC;
   localparam logic [ANG_W-1:0] ONE_Q60_BY_5   = ONE_Q60 / 5;
   localparam logic [ANG_W-1:0] ONE_Q60_BY_239 = ONE_Q60 / 239;

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_MUL   = 3'd2,
      OP_DIV   = 3'd3,
      OP_MAG   = 3'd4,
      OP_ANGLE = 3'd5
   } op_type;

   typedef logic signed [DATA_WIDTH-1:0] word_type;
   typedef logic signed [ANG_W-1:0]      ang_type;

   typedef struct packed {
      logic                 valid;
      op_type               op;
      word_type             simple_real;
      word_type             simple_imag;
      logic                 simple_sat;
      logic                 div_zero;
      logic                 div_big_r;
      logic                 div_big_i;
      logic                 num_neg_r;
      logic                 num_neg_i;
      logic [MAG_W-1:0]     div_d;
      logic [MAG_W-1:0]     rem_r;
      logic [MAG_W-1:0]     rem_i;
      logic [LOW_W-1:0]     low_r;
      logic [LOW_W-1:0]     low_i;
      logic [QUO_W-1:0]     quo_r;
      logic [QUO_W-1:0]     quo_i;
      logic [PROD_W-1:0]    sq_rem;
      logic [PROD_W-1:0]    sq_res;
      logic                 ang_zero;
      logic                 re_neg;
      logic                 im_neg;
      ang_type              cx;
      ang_type              cy;
      ang_type              cz;
   } chain_type;

   function automatic logic [ANG_W-1:0] mag_of(input ang_type v);
      return v[ANG_W-1] ? ANG_W'(-v) : ANG_W'(v);
   endfunction

   // Saturates a sign and magnitude to one word; the top bit flags saturation.
   function automatic logic [DATA_WIDTH:0] sat_pack(input logic neg,
                                                    input logic [ANG_W-1:0] mag);
      logic [ANG_W-1:0]      lim;
      logic [DATA_WIDTH-1:0] val;
      logic                  sat;
      lim = ANG_W'(1) << (DATA_WIDTH - 1);
      sat = 1'b0;
      if (neg) begin
         if (mag > lim) begin
            sat = 1'b1;
            val = lim[DATA_WIDTH-1:0];
         end else begin
            val = DATA_WIDTH'(ANG_W'(0) - mag);
         end
      end else begin
         if (mag > lim - ANG_W'(1)) begin
            sat = 1'b1;
            val = DATA_WIDTH'(lim - ANG_W'(1));
         end else begin
            val = mag[DATA_WIDTH-1:0];
         end
      end
      return {sat, val};
   endfunction

   // Restoring long division, used only while the angle constants are built.
   function automatic logic [ANG_W-1:0] const_quotient(input logic [ANG_W-1:0] num,
                                                       input logic [ANG_W-1:0] den);
      logic [ANG_W-1:0] rem;
      logic [ANG_W-1:0] quo;
      rem = '0;
      quo = '0;
      for (int i = ANG_W - 1; i >= 0; i--) begin
         rem = {rem[ANG_W-2:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Arctangent of 2^-idx in Q.60 from its Taylor series; entry zero is pi/4
   // by the Machin formula. Evaluated only for constant arguments.
   function automatic ang_type atan_entry(input int idx);
      logic [ANG_W-1:0] t;
      logic [ANG_W-1:0] t5;
      logic [ANG_W-1:0] t239;
      logic [ANG_W-1:0] k;
      logic [ANG_W-1:0] term;
      ang_type          s5;
      ang_type          s239;
      ang_type          acc;
      logic             minus;
      int               n;
      s5    = '0;
      s239  = '0;
      acc   = '0;
      t5    = ONE_Q60_BY_5;
      k     = ANG_W'(1);
      minus = 1'b0;
      for (n = 0; n < ANG_W; n++) begin
         if (t5 != '0) begin
            term  = const_quotient(t5, k);
            s5    = minus ? s5 - ang_type'(term) : s5 + ang_type'(term);
            t5    = const_quotient(t5, ANG_W'(25));
            k     = k + ANG_W'(2);
            minus = !minus;
         end
      end
      t239  = ONE_Q60_BY_239;
      k     = ANG_W'(1);
      minus = 1'b0;
      for (n = 0; n < ANG_W; n++) begin
         if (t239 != '0) begin
            term  = const_quotient(t239, k);
            s239  = minus ? s239 - ang_type'(term) : s239 + ang_type'(term);
            t239  = const_quotient(t239, ANG_W'(57121));
            k     = k + ANG_W'(2);
            minus = !minus;
         end
      end
      t     = ONE_Q60 >> idx;
      k     = ANG_W'(1);
      minus = 1'b0;
      for (n = 0; n < ANG_W; n++) begin
         if (t != '0) begin
            term  = const_quotient(t, k);
            acc   = minus ? acc - ang_type'(term) : acc + ang_type'(term);
            t     = t >> (2 * idx);
            k     = k + ANG_W'(2);
            minus = !minus;
         end
      end
      if (idx == 0) begin
         return (s5 <<< 2) - s239;
      end
      return acc;
   endfunction

   localparam ang_type PI_Q = atan_entry(0) <<< 2;

endpackage

`default_nettype wire

FILE: design/cau_ifs.sv
// Request and response channel interfaces of the complex arithmetic unit.
// Depends on cau_pkg.
`default_nettype none

interface cau_req_if;
   import cau_pkg::*;
   logic            valid;
   logic            ready;
   logic [OP_W-1:0] operation;
   word_type        a_real;
   word_type        a_imag;
   word_type        b_real;
   word_type        b_imag;
   modport source (output valid, operation, a_real, a_imag, b_real, b_imag,
                   input ready);
   modport sink (input valid, operation, a_real, a_imag, b_real, b_imag,
                 output ready);
endinterface

interface cau_rsp_if;
   import cau_pkg::*;
   logic     valid;
   logic     ready;
   word_type result_real;
   word_type result_imag;
   logic     overflow;
   logic     divide_by_zero;
   modport source (output valid, result_real, result_imag, overflow, divide_by_zero,
                   input ready);
   modport sink (input valid, result_real, result_imag, overflow, divide_by_zero,
                 output ready);
endinterface

`default_nettype wire

FILE: design/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply, divide, magnitude, angle.
// One request is taken every cycle while the skid register is empty, with
// the depth set by the 61-cell CORDIC chain.
// A stalled output holds the chain once the skid register is full.
// Synchronous reset clears all valid bits; the datapath registers keep data.
// Depends on cau_pkg, cau_ifs, cau_front, cau_cell and cau_back.
`default_nettype none

module complex_arithmetic_unit (
   input logic       clock,
   input logic       reset,
   cau_req_if.sink   req_chan,
   cau_rsp_if.source rsp_chan
);
   import cau_pkg::*;

   logic      advance;
   chain_type chain [CORDIC_N+1];

   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_chan.valid),
      .in_op    (op_type'(req_chan.operation)),
      .in_ar    (req_chan.a_real),
      .in_ai    (req_chan.a_imag),
      .in_br    (req_chan.b_real),
      .in_bi    (req_chan.b_imag),
      .out_data (chain[0])
   );

   for (genvar g = 0; g < CORDIC_N; g++) begin : g_cell
      localparam ang_type STEP_ANGLE = atan_entry(g);
      cau_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .step_idx   (STEP_W'(g)),
         .step_angle (STEP_ANGLE),
         .in_data    (chain[g]),
         .out_data   (chain[g+1])
      );
   end

   cau_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_data      (chain[CORDIC_N]),
      .rsp_ready    (rsp_chan.ready),
      .advance      (advance),
      .rsp_valid    (rsp_chan.valid),
      .rsp_real     (rsp_chan.result_real),
      .rsp_imag     (rsp_chan.result_imag),
      .rsp_overflow (rsp_chan.overflow),
      .rsp_dbz      (rsp_chan.divide_by_zero)
   );

   assign req_chan.ready = advance;

   a_dbz_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.divide_by_zero |->
         rsp_chan.result_real == '0 && rsp_chan.result_imag == '0 && !rsp_chan.overflow)
      else $error("divide by zero result is not cleared");

   a_hold_cause: assert property (@(posedge clock) disable iff (reset)
      $fell(advance) |-> $past(rsp_chan.valid && !rsp_chan.ready))
      else $error("request side stalled without a stalled response");

endmodule

`default_nettype wire

FILE: design/cau_front.sv
// Front end: operand products, then sums, add/sub/multiply results and the
// starting values of the division, square root and CORDIC lanes. Uses cau_pkg.
`default_nettype none

module cau_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  cau_pkg::op_type     in_op,
   input  cau_pkg::word_type   in_ar,
   input  cau_pkg::word_type   in_ai,
   input  cau_pkg::word_type   in_br,
   input  cau_pkg::word_type   in_bi,
   output cau_pkg::chain_type  out_data
);
   import cau_pkg::*;

   typedef struct packed {
      logic                     valid;
      op_type                   op;
      word_type                 ar;
      word_type                 ai;
      word_type                 br;
      word_type                 bi;
      logic signed [PROD_W-1:0] p_rr;
      logic signed [PROD_W-1:0] p_ii;
      logic signed [PROD_W-1:0] p_ri;
      logic signed [PROD_W-1:0] p_ir;
      logic signed [PROD_W-1:0] p_asq_r;
      logic signed [PROD_W-1:0] p_asq_i;
      logic signed [PROD_W-1:0] p_bsq_r;
      logic signed [PROD_W-1:0] p_bsq_i;
   } stage_a_type;

   stage_a_type stage_a_in, stage_a_ff;
   chain_type   stage_b_in, stage_b_ff;

   logic signed [UMAG_W-1:0] add_r, add_i;
   logic signed [SUM_W-1:0]  mul_r, mul_i, num_r, num_i;
   logic [DATA_WIDTH:0]      add_pr, add_pi, mul_pr, mul_pi;
   logic [MAG_W-1:0]         num_mag_r, num_mag_i, den;
   logic [UMAG_W-1:0]        ux, uy, or_v;
   logic [MSB_W-1:0]         msb;
   logic [SHIFT_W-1:0]       norm_sh;

   always_comb begin
      stage_a_in.valid   = in_valid;
      stage_a_in.op      = in_op;
      stage_a_in.ar      = in_ar;
      stage_a_in.ai      = in_ai;
      stage_a_in.br      = in_br;
      stage_a_in.bi      = in_bi;
      stage_a_in.p_rr    = in_ar * in_br;
      stage_a_in.p_ii    = in_ai * in_bi;
      stage_a_in.p_ri    = in_ar * in_bi;
      stage_a_in.p_ir    = in_ai * in_br;
      stage_a_in.p_asq_r = in_ar * in_ar;
      stage_a_in.p_asq_i = in_ai * in_ai;
      stage_a_in.p_bsq_r = in_br * in_br;
      stage_a_in.p_bsq_i = in_bi * in_bi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_a_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_a_ff <= stage_a_in;
      end
   end

   always_comb begin
      if (stage_a_ff.op == OP_SUB) begin
         add_r = UMAG_W'(stage_a_ff.ar) - UMAG_W'(stage_a_ff.br);
         add_i = UMAG_W'(stage_a_ff.ai) - UMAG_W'(stage_a_ff.bi);
      end else begin
         add_r = UMAG_W'(stage_a_ff.ar) + UMAG_W'(stage_a_ff.br);
         add_i = UMAG_W'(stage_a_ff.ai) + UMAG_W'(stage_a_ff.bi);
      end
      add_pr = sat_pack(add_r < 0, mag_of(ang_type'(add_r)));
      add_pi = sat_pack(add_i < 0, mag_of(ang_type'(add_i)));

      mul_r  = SUM_W'(stage_a_ff.p_rr) - SUM_W'(stage_a_ff.p_ii);
      mul_i  = SUM_W'(stage_a_ff.p_ri) + SUM_W'(stage_a_ff.p_ir);
      mul_pr = sat_pack(mul_r < 0, (mag_of(ang_type'(mul_r))
                                    + (ANG_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
      mul_pi = sat_pack(mul_i < 0, (mag_of(ang_type'(mul_i))
                                    + (ANG_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);

      num_r     = SUM_W'(stage_a_ff.p_rr) + SUM_W'(stage_a_ff.p_ii);
      num_i     = SUM_W'(stage_a_ff.p_ir) - SUM_W'(stage_a_ff.p_ri);
      num_mag_r = MAG_W'(mag_of(ang_type'(num_r)));
      num_mag_i = MAG_W'(mag_of(ang_type'(num_i)));
      den       = MAG_W'($unsigned(stage_a_ff.p_bsq_r)) + MAG_W'($unsigned(stage_a_ff.p_bsq_i));

      ux   = UMAG_W'(mag_of(ang_type'(stage_a_ff.ar)));
      uy   = UMAG_W'(mag_of(ang_type'(stage_a_ff.ai)));
      or_v = ux | uy;
      msb  = '0;
      for (int b = 0; b < UMAG_W; b++) begin
         if (or_v[b]) begin
            msb = MSB_W'(b);
         end
      end
      norm_sh = SHIFT_W'(NORM_MSB) - SHIFT_W'(msb);

      stage_b_in.valid = stage_a_ff.valid;
      stage_b_in.op    = stage_a_ff.op;
      if (stage_a_ff.op == OP_MUL) begin
         stage_b_in.simple_real = mul_pr[DATA_WIDTH-1:0];
         stage_b_in.simple_imag = mul_pi[DATA_WIDTH-1:0];
         stage_b_in.simple_sat  = mul_pr[DATA_WIDTH] | mul_pi[DATA_WIDTH];
      end else begin
         stage_b_in.simple_real = add_pr[DATA_WIDTH-1:0];
         stage_b_in.simple_imag = add_pi[DATA_WIDTH-1:0];
         stage_b_in.simple_sat  = add_pr[DATA_WIDTH] | add_pi[DATA_WIDTH];
      end
      stage_b_in.div_zero  = (stage_a_ff.br == '0) && (stage_a_ff.bi == '0);
      stage_b_in.div_big_r = {LOW_W'(0), num_mag_r} >= {den, LOW_W'(0)};
      stage_b_in.div_big_i = {LOW_W'(0), num_mag_i} >= {den, LOW_W'(0)};
      stage_b_in.num_neg_r = num_r < 0;
      stage_b_in.num_neg_i = num_i < 0;
      stage_b_in.div_d     = den;
      stage_b_in.rem_r     = num_mag_r >> LOW_W;
      stage_b_in.rem_i     = num_mag_i >> LOW_W;
      stage_b_in.low_r     = num_mag_r[LOW_W-1:0];
      stage_b_in.low_i     = num_mag_i[LOW_W-1:0];
      stage_b_in.quo_r     = '0;
      stage_b_in.quo_i     = '0;
      stage_b_in.sq_rem    = MAG_W'($unsigned(stage_a_ff.p_asq_r))
                           + MAG_W'($unsigned(stage_a_ff.p_asq_i));
      stage_b_in.sq_res    = '0;
      stage_b_in.ang_zero  = (or_v == '0);
      stage_b_in.re_neg    = stage_a_ff.ar < 0;
      stage_b_in.im_neg    = stage_a_ff.ai < 0;
      stage_b_in.cx        = ang_type'(ANG_W'(ux) << norm_sh);
      stage_b_in.cy        = ang_type'(ANG_W'(uy) << norm_sh);
      stage_b_in.cz        = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_b_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_b_ff <= stage_b_in;
      end
   end

   assign out_data = stage_b_ff;

endmodule

`default_nettype wire

FILE: design/cau_cell.sv
// One cell of the chain: a CORDIC rotation, and in the leading cells one
// quotient bit per division lane and one root bit. Uses cau_pkg.
`default_nettype none

module cau_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [cau_pkg::STEP_W-1:0] step_idx,
   input  cau_pkg::ang_type          step_angle,
   input  cau_pkg::chain_type        in_data,
   output cau_pkg::chain_type        out_data
);
   import cau_pkg::*;

   chain_type           data_in, data_ff;
   logic [MAG_W:0]      cat_r, cat_i;
   logic                qbit_r, qbit_i;
   logic [PROD_W-1:0]   sq_bit;
   logic [PROD_W:0]     trial;
   ang_type             dx, dy;

   always_comb begin
      data_in = in_data;
      cat_r   = {in_data.rem_r, in_data.low_r[LOW_W-1]};
      cat_i   = {in_data.rem_i, in_data.low_i[LOW_W-1]};
      qbit_r  = cat_r >= {1'b0, in_data.div_d};
      qbit_i  = cat_i >= {1'b0, in_data.div_d};
      sq_bit  = PROD_W'(1) << (STEP_W'(2 * (SQRT_STEPS - 1)) - (step_idx << 1));
      trial   = {1'b0, in_data.sq_res} + {1'b0, sq_bit};
      dx      = in_data.cy >>> step_idx;
      dy      = in_data.cx >>> step_idx;

      if (step_idx < STEP_W'(QUO_W)) begin
         data_in.rem_r = qbit_r ? MAG_W'(cat_r - {1'b0, in_data.div_d}) : MAG_W'(cat_r);
         data_in.rem_i = qbit_i ? MAG_W'(cat_i - {1'b0, in_data.div_d}) : MAG_W'(cat_i);
         data_in.low_r = in_data.low_r << 1;
         data_in.low_i = in_data.low_i << 1;
         data_in.quo_r = {in_data.quo_r[QUO_W-2:0], qbit_r};
         data_in.quo_i = {in_data.quo_i[QUO_W-2:0], qbit_i};
      end

      if (step_idx < STEP_W'(SQRT_STEPS)) begin
         if ({1'b0, in_data.sq_rem} >= trial) begin
            data_in.sq_rem = PROD_W'({1'b0, in_data.sq_rem} - trial);
            data_in.sq_res = (in_data.sq_res >> 1) + sq_bit;
         end else begin
            data_in.sq_res = in_data.sq_res >> 1;
         end
      end

      // Rotate toward the x axis; the angle register collects the rotation.
      if (in_data.cy > 0) begin
         data_in.cx = in_data.cx + dx;
         data_in.cy = in_data.cy - dy;
         data_in.cz = in_data.cz + step_angle;
      end else begin
         data_in.cx = in_data.cx - dx;
         data_in.cy = in_data.cy + dy;
         data_in.cz = in_data.cz - step_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_data = data_ff;

endmodule

`default_nettype wire

FILE: design/cau_back.sv
// Back end: quotient and root rounding, angle quadrant mapping, result
// selection, output register and skid register. Uses cau_pkg.
`default_nettype none

module cau_back (
   input  logic               clock,
   input  logic               reset,
   input  cau_pkg::chain_type in_data,
   input  logic               rsp_ready,
   output logic               advance,
   output logic               rsp_valid,
   output cau_pkg::word_type  rsp_real,
   output cau_pkg::word_type  rsp_imag,
   output logic               rsp_overflow,
   output logic               rsp_dbz
);
   import cau_pkg::*;

   typedef struct packed {
      logic              valid;
      op_type            op;
      word_type          simple_real;
      word_type          simple_imag;
      logic              simple_sat;
      logic              div_zero;
      logic              num_neg_r;
      logic              num_neg_i;
      logic [QUO_W-1:0]  qr_r;
      logic [QUO_W-1:0]  qr_i;
      logic [UMAG_W-1:0] root;
      logic              ang_zero;
      logic              im_neg;
      ang_type           z1;
   } back_type;

   typedef struct packed {
      word_type re_part;
      word_type imag_part;
      logic     overflow;
      logic     dbz;
   } result_type;

   back_type            back_in, back_ff;
   result_type          res_in, out_in, out_ff, skid_in, skid_ff;
   logic                out_valid_in, out_valid_ff, skid_valid_in, skid_valid_ff;
   logic                incoming;
   logic [DATA_WIDTH:0] pk_r, pk_i, pk_root, pk_ang;
   logic [ANG_W-1:0]    ang_round;

   assign advance = !skid_valid_ff;

   always_comb begin
      back_in.valid       = in_data.valid;
      back_in.op          = in_data.op;
      back_in.simple_real = in_data.simple_real;
      back_in.simple_imag = in_data.simple_imag;
      back_in.simple_sat  = in_data.simple_sat;
      back_in.div_zero    = in_data.div_zero;
      back_in.num_neg_r   = in_data.num_neg_r;
      back_in.num_neg_i   = in_data.num_neg_i;
      back_in.qr_r = in_data.div_big_r ? QUO_W'(1) << (QUO_W - 1)
                                       : QUO_W'(({1'b0, in_data.quo_r} + 1'b1) >> 1);
      back_in.qr_i = in_data.div_big_i ? QUO_W'(1) << (QUO_W - 1)
                                       : QUO_W'(({1'b0, in_data.quo_i} + 1'b1) >> 1);
      back_in.root = UMAG_W'(in_data.sq_res)
                   + UMAG_W'(in_data.sq_rem > in_data.sq_res);
      back_in.ang_zero = in_data.ang_zero;
      back_in.im_neg   = in_data.im_neg;
      back_in.z1       = in_data.re_neg ? PI_Q - in_data.cz : in_data.cz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         back_ff.valid <= 1'b0;
      end else if (advance) begin
         back_ff <= back_in;
      end
   end

   always_comb begin
      pk_r      = sat_pack(back_ff.num_neg_r, ANG_W'(back_ff.qr_r));
      pk_i      = sat_pack(back_ff.num_neg_i, ANG_W'(back_ff.qr_i));
      pk_root   = sat_pack(1'b0, ANG_W'(back_ff.root));
      ang_round = (mag_of(back_ff.z1) + (ANG_W'(1) << (ANG_SHIFT - 1))) >> ANG_SHIFT;
      pk_ang    = sat_pack(back_ff.z1[ANG_W-1] ^ back_ff.im_neg, ang_round);
      res_in    = '0;
      case (back_ff.op)
         OP_ADD, OP_SUB, OP_MUL: begin
            res_in.re_part   = back_ff.simple_real;
            res_in.imag_part = back_ff.simple_imag;
            res_in.overflow  = back_ff.simple_sat;
         end
         OP_DIV: begin
            if (back_ff.div_zero) begin
               res_in.dbz = 1'b1;
            end else begin
               res_in.re_part   = pk_r[DATA_WIDTH-1:0];
               res_in.imag_part = pk_i[DATA_WIDTH-1:0];
               res_in.overflow  = pk_r[DATA_WIDTH] | pk_i[DATA_WIDTH];
            end
         end
         OP_MAG: begin
            res_in.re_part  = pk_root[DATA_WIDTH-1:0];
            res_in.overflow = pk_root[DATA_WIDTH];
         end
         OP_ANGLE: begin
            if (!back_ff.ang_zero) begin
               res_in.re_part  = pk_ang[DATA_WIDTH-1:0];
               res_in.overflow = pk_ang[DATA_WIDTH];
            end
         end
         default: begin
            res_in = '0;
         end
      endcase
   end

   // A result that arrives while the output is stalled parks in the skid
   // register, which then holds the chain until the output drains.
   assign incoming = back_ff.valid && advance;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res_in;
            out_valid_in = incoming;
         end
      end else if (incoming) begin
         skid_in       = res_in;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_real     = out_ff.re_part;
   assign rsp_imag     = out_ff.imag_part;
   assign rsp_overflow = out_ff.overflow;
   assign rsp_dbz      = out_ff.dbz;

endmodule

`default_nettype wire
